>>> rtl/rdec_pkg.sv
// Shared types, codes and the rotation phase table for the rotary encoder decoder.
// Has no dependencies; every rtl file imports it.
package rdec_pkg;

  // Configuration register indexes.
  localparam logic REG_THRESHOLD  = 1'b0;
  localparam logic REG_INIT_LEVEL = 1'b1;

  localparam int unsigned CFG_WIDTH = 8;
  localparam int unsigned CNT_WIDTH = 8;
  localparam int unsigned PH_WIDTH  = 4;

  localparam logic [CNT_WIDTH-1:0] THRESHOLD_RESET = 8'd4;
  localparam logic                 INIT_LEVEL_RESET = 1'b1;

  // Detent direction codes.
  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;

  // Rotation phases: idle, three left steps, left fire, three right steps, right fire.
  localparam logic [PH_WIDTH-1:0] PH_IDLE       = 4'd0;
  localparam logic [PH_WIDTH-1:0] PH_LEFT_1     = 4'd1;
  localparam logic [PH_WIDTH-1:0] PH_LEFT_2     = 4'd2;
  localparam logic [PH_WIDTH-1:0] PH_LEFT_3     = 4'd3;
  localparam logic [PH_WIDTH-1:0] PH_LEFT_FIRE  = 4'd4;
  localparam logic [PH_WIDTH-1:0] PH_RIGHT_1    = 4'd5;
  localparam logic [PH_WIDTH-1:0] PH_RIGHT_2    = 4'd6;
  localparam logic [PH_WIDTH-1:0] PH_RIGHT_3    = 4'd7;
  localparam logic [PH_WIDTH-1:0] PH_RIGHT_FIRE = 4'd8;

  typedef struct packed {
    logic pin_a;
    logic pin_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0] direction;
    logic       level_a;
    logic       level_b;
  } out_item_t;

  // Debounce state of one channel.
  typedef struct packed {
    logic                 level;
    logic [CNT_WIDTH-1:0] count;
  } chan_state_t;

  // Next phase for a phase and an event (A in bit 0, B in bit 1).
  function automatic logic [PH_WIDTH-1:0] next_phase(input logic [PH_WIDTH-1:0] phase,
                                                     input logic [1:0] evt);
    logic [PH_WIDTH-1:0] res;
    res = PH_IDLE;
    unique case (phase)
      PH_LEFT_1: begin
        unique case (evt)
          2'd0:    res = PH_LEFT_2;
          2'd1:    res = PH_LEFT_1;
          default: res = PH_IDLE;
        endcase
      end
      PH_LEFT_2: begin
        unique case (evt)
          2'd0:    res = PH_LEFT_2;
          2'd2:    res = PH_LEFT_3;
          default: res = PH_IDLE;
        endcase
      end
      PH_LEFT_3: begin
        unique case (evt)
          2'd2:    res = PH_LEFT_3;
          2'd3:    res = PH_LEFT_FIRE;
          default: res = PH_IDLE;
        endcase
      end
      PH_RIGHT_1: begin
        unique case (evt)
          2'd0:    res = PH_RIGHT_2;
          2'd2:    res = PH_RIGHT_1;
          default: res = PH_IDLE;
        endcase
      end
      PH_RIGHT_2: begin
        unique case (evt)
          2'd0:    res = PH_RIGHT_2;
          2'd1:    res = PH_RIGHT_3;
          default: res = PH_IDLE;
        endcase
      end
      PH_RIGHT_3: begin
        unique case (evt)
          2'd1:    res = PH_RIGHT_3;
          2'd3:    res = PH_RIGHT_FIRE;
          default: res = PH_IDLE;
        endcase
      end
      // Idle, both fire phases and unused codes share the idle row.
      default: begin
        unique case (evt)
          2'd1:    res = PH_LEFT_1;
          2'd2:    res = PH_RIGHT_1;
          default: res = PH_IDLE;
        endcase
      end
    endcase
    return res;
  endfunction

endpackage

>>> rtl/rdec_filter.sv
// Debounce update for one encoder channel: next level and mismatch count.
// Depends on rdec_pkg.
module rdec_filter (
  input  rdec_pkg::chan_state_t                  cur,
  input  logic                                   raw,
  input  logic [rdec_pkg::CNT_WIDTH-1:0]         threshold,
  output rdec_pkg::chan_state_t                  nxt
);
  import rdec_pkg::*;

  // A differing raw level counts up until it has outlasted the threshold.
  always_comb begin
    nxt = cur;
    if (cur.level != raw) begin
      if (cur.count < threshold) begin
        nxt.count = cur.count + CNT_WIDTH'(1);
      end else begin
        nxt.count = '0;
        nxt.level = raw;
      end
    end else begin
      nxt.count = '0;
    end
  end

endmodule

>>> rtl/rdec_phase.sv
// Rotation phase step: table lookup, detent detection and return to idle.
// Depends on rdec_pkg.
module rdec_phase (
  input  logic [rdec_pkg::PH_WIDTH-1:0] phase,
  input  logic                          level_a,
  input  logic                          level_b,
  output logic [rdec_pkg::PH_WIDTH-1:0] phase_nxt,
  output logic [1:0]                    direction
);
  import rdec_pkg::*;

  logic [PH_WIDTH-1:0] looked_up;

  assign looked_up = next_phase(phase, {level_b, level_a});

  // A fire phase reports its detent and falls straight back to idle.
  always_comb begin
    phase_nxt = looked_up;
    direction = DIR_NONE;
    if (looked_up == PH_LEFT_FIRE) begin
      direction = DIR_LEFT;
      phase_nxt = PH_IDLE;
    end else if (looked_up == PH_RIGHT_FIRE) begin
      direction = DIR_RIGHT;
      phase_nxt = PH_IDLE;
    end
  end

endmodule

>>> rtl/debounced_rotary_encoder_decoder_unit.sv
// Debounced quadrature rotary encoder decoder, top level.
// A result passes through the input register and then the result register.
// Throughput: one item per cycle while out_stall is low; the state update is a single registered pass.
// The result register holds a valid result while out_stall is high; the input register takes one more item
// and then stalls the input until the result is taken.
// Synchronous active-low reset: threshold 4, initial level 1, levels 1, counters 0, phase idle, valid flags 0.
// Depends on rdec_pkg, rdec_filter and rdec_phase.
module debounced_rotary_encoder_decoder_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rdec_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rdec_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [rdec_pkg::CFG_WIDTH-1:0]  cfg_wdata
);
  import rdec_pkg::*;

  logic [CNT_WIDTH-1:0] threshold_r;
  logic                 init_level_r;
  logic                 in_valid_r;
  in_item_t             in_data_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;
  chan_state_t          chan_a_r, chan_b_r;
  chan_state_t          chan_a_nxt, chan_b_nxt;
  logic [PH_WIDTH-1:0]  phase_r, phase_nxt;
  logic [1:0]           dir_nxt;
  logic                 level_a_nxt, level_b_nxt;
  logic                 advance;
  logic                 step;

  // The result stage moves when it is empty or its result is being taken.
  assign advance  = !out_valid_r || !out_stall;
  assign step     = advance && in_valid_r;
  assign in_stall = in_valid_r && !advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESHOLD_RESET;
      init_level_r <= INIT_LEVEL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:  threshold_r  <= cfg_wdata;
        REG_INIT_LEVEL: init_level_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // Per-channel debounce.
  rdec_filter u_filter_a (
    .cur       (chan_a_r),
    .raw       (in_data_r.pin_a),
    .threshold (threshold_r),
    .nxt       (chan_a_nxt)
  );

  rdec_filter u_filter_b (
    .cur       (chan_b_r),
    .raw       (in_data_r.pin_b),
    .threshold (threshold_r),
    .nxt       (chan_b_nxt)
  );

  // Phase table driven by the freshly debounced levels.
  rdec_phase u_phase (
    .phase     (phase_r),
    .level_a   (chan_a_nxt.level),
    .level_b   (chan_b_nxt.level),
    .phase_nxt (phase_nxt),
    .direction (dir_nxt)
  );

  // An idle table forces both levels back to the initial level; counters are kept.
  assign level_a_nxt = (phase_nxt == PH_IDLE) ? init_level_r : chan_a_nxt.level;
  assign level_b_nxt = (phase_nxt == PH_IDLE) ? init_level_r : chan_b_nxt.level;

  // Decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_a_r <= '{level: INIT_LEVEL_RESET, count: '0};
      chan_b_r <= '{level: INIT_LEVEL_RESET, count: '0};
      phase_r  <= PH_IDLE;
    end else if (step) begin
      chan_a_r <= '{level: level_a_nxt, count: chan_a_nxt.count};
      chan_b_r <= '{level: level_b_nxt, count: chan_b_nxt.count};
      phase_r  <= phase_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= '{direction: dir_nxt, level_a: level_a_nxt, level_b: level_b_nxt};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/rdec_checker.sv
// Port-level checker for the rotary encoder decoder, bound to the top level.
// Depends on rdec_pkg.
module rdec_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input rdec_pkg::out_item_t out_data
);
  import rdec_pkg::*;

  // No result is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The direction code is never the unused value.
  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.direction == DIR_NONE || out_data.direction == DIR_LEFT ||
                   out_data.direction == DIR_RIGHT))
    else $error("direction code out of range");

  // A detent returns the table to idle, so both levels are the initial level.
  a_fire_levels: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.direction != DIR_NONE) |-> (out_data.level_a == out_data.level_b))
    else $error("levels differ on a detent");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind debounced_rotary_encoder_decoder_unit rdec_checker u_rdec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
